// File: rtl/core/ihex_pkg.sv
package ihex_pkg;

  localparam int RECORD_BYTES = 16;
  localparam int LENGTH_BITS  = 24;
  localparam int REC_W        = $clog2(RECORD_BYTES + 1);

  localparam int QUEUE_DEPTH  = 2;
  localparam int QPTR_W       = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_W       = $clog2(QUEUE_DEPTH + 1);

  // Character positions of one transaction's text; segments are contiguous
  // so the back end only ever steps by one.
  localparam int POS_W = 6;
  localparam logic [POS_W-1:0] P_EXT       = 6'd0;
  localparam logic [POS_W-1:0] P_HDR       = 6'd16;
  localparam logic [POS_W-1:0] P_DATA      = 6'd25;
  localparam logic [POS_W-1:0] P_DATA_END  = 6'd26;
  localparam logic [POS_W-1:0] P_CLOSE     = 6'd27;
  localparam logic [POS_W-1:0] P_CLOSE_END = 6'd29;
  localparam logic [POS_W-1:0] P_EOF       = 6'd30;
  localparam logic [POS_W-1:0] P_EOF_END   = 6'd41;

  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_NL    = 8'h0A;
  localparam logic [7:0] CH_0     = 8'h30;
  localparam logic [7:0] CH_1     = 8'h31;
  localparam logic [7:0] CH_2     = 8'h32;
  localparam logic [7:0] CH_4     = 8'h34;
  localparam logic [7:0] CH_F     = 8'h46;

  typedef struct packed {
    logic        ext;
    logic [15:0] hi;
    logic [7:0]  ext_ck;
    logic        hdr;
    logic [7:0]  rec;
    logic [15:0] lo;
    logic [7:0]  data;
    logic        close;
    logic [7:0]  close_ck;
    logic        eof;
  } cmd_t;

  function automatic logic [7:0] hex_char(input logic [3:0] v);
    logic [7:0] r;
    if (v < 4'd10) begin
      r = CH_0 + {4'b0000, v};
    end else begin
      r = 8'h37 + {4'b0000, v};
    end
    return r;
  endfunction

endpackage

// File: rtl/core/ihex_front.sv
module ihex_front
  import ihex_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic [31:0]            base_address,
  input  logic [LENGTH_BITS-1:0] payload_length,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic [7:0]             data_byte,
  input  logic                   full,
  output logic                   push,
  output cmd_t                   cmd
);

  logic [LENGTH_BITS-1:0] byte_offset;
  logic [15:0]            upper_address;
  logic                   upper_valid;
  logic [7:0]             record_sum;
  logic [REC_W-1:0]       record_left;

  logic [LENGTH_BITS-1:0] rem;
  logic [LENGTH_BITS-1:0] off1;
  logic [REC_W-1:0]       rec;
  logic [31:0]            addr;
  logic                   open_rec;
  logic                   page_change;
  logic [7:0]             hdr_sum;
  logic [7:0]             sum_new;
  logic [REC_W-1:0]       rl_after;
  logic                   run_done;
  logic                   close_rec;

  assign in_stall = full;
  assign push     = in_valid && !full && (byte_offset < payload_length);

  always_comb begin
    rem      = payload_length - byte_offset;
    rec      = (rem > LENGTH_BITS'(RECORD_BYTES)) ? REC_W'(RECORD_BYTES) : rem[REC_W-1:0];
    addr     = base_address + 32'(byte_offset);
    open_rec = (record_left == '0);
    page_change = open_rec && (!upper_valid || (addr[31:16] != upper_address));
    hdr_sum  = 8'(rec) + addr[15:8] + addr[7:0];
    sum_new  = (open_rec ? hdr_sum : record_sum) + data_byte;
    rl_after = (open_rec ? rec : record_left) - REC_W'(1);
    off1     = byte_offset + LENGTH_BITS'(1);
    run_done = (off1 >= payload_length);
    close_rec = (rl_after == '0) || run_done;

    cmd.ext      = page_change;
    cmd.hi       = addr[31:16];
    cmd.ext_ck   = 8'h00 - (8'd6 + addr[31:24] + addr[23:16]);
    cmd.hdr      = open_rec;
    cmd.rec      = 8'(rec);
    cmd.lo       = addr[15:0];
    cmd.data     = data_byte;
    cmd.close    = close_rec;
    cmd.close_ck = 8'h00 - sum_new;
    cmd.eof      = run_done;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_offset   <= '0;
      upper_address <= '0;
      upper_valid   <= 1'b0;
      record_sum    <= '0;
      record_left   <= '0;
    end else if (push) begin
      byte_offset <= off1;
      if (page_change) begin
        upper_address <= addr[31:16];
        upper_valid   <= 1'b1;
      end
      record_sum  <= close_rec ? 8'h00 : sum_new;
      record_left <= close_rec ? '0 : rl_after;
    end
  end

endmodule

// File: rtl/core/ihex_queue.sv
module ihex_queue
  import ihex_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  cmd_t wr_cmd,
  output logic full,
  input  logic pop,
  output cmd_t rd_cmd,
  output logic empty
);

  cmd_t              entries [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;

  assign full   = (count == QCNT_W'(QUEUE_DEPTH));
  assign empty  = (count == '0);
  assign rd_cmd = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= wr_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + QPTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + QPTR_W'(1);
      end
      if (push && !pop) begin
        count <= count + QCNT_W'(1);
      end else if (pop && !push) begin
        count <= count - QCNT_W'(1);
      end
    end
  end

endmodule

// File: rtl/core/ihex_back.sv
module ihex_back
  import ihex_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  cmd_t       cmd,
  input  logic       empty,
  output logic       pop,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_char,
  output logic       last_char
);

  logic             started;
  logic [POS_W-1:0] pos;
  logic [POS_W-1:0] start_pos;
  logic [POS_W-1:0] cur;
  logic             fire;

  assign start_pos = cmd.ext ? P_EXT : (cmd.hdr ? P_HDR : P_DATA);
  assign cur       = started ? pos : start_pos;
  assign out_valid = !empty;
  assign fire      = out_valid && !out_stall;
  assign last_char = ((cur == P_DATA_END) && !cmd.close) ||
                     ((cur == P_CLOSE_END) && !cmd.eof) ||
                     (cur == P_EOF_END);
  assign pop       = fire && last_char;

  always_comb begin
    case (cur)
      6'd0:    out_char = CH_COLON;
      6'd1:    out_char = CH_0;
      6'd2:    out_char = CH_2;
      6'd3:    out_char = CH_0;
      6'd4:    out_char = CH_0;
      6'd5:    out_char = CH_0;
      6'd6:    out_char = CH_0;
      6'd7:    out_char = CH_0;
      6'd8:    out_char = CH_4;
      6'd9:    out_char = hex_char(cmd.hi[15:12]);
      6'd10:   out_char = hex_char(cmd.hi[11:8]);
      6'd11:   out_char = hex_char(cmd.hi[7:4]);
      6'd12:   out_char = hex_char(cmd.hi[3:0]);
      6'd13:   out_char = hex_char(cmd.ext_ck[7:4]);
      6'd14:   out_char = hex_char(cmd.ext_ck[3:0]);
      6'd15:   out_char = CH_NL;
      6'd16:   out_char = CH_COLON;
      6'd17:   out_char = hex_char(cmd.rec[7:4]);
      6'd18:   out_char = hex_char(cmd.rec[3:0]);
      6'd19:   out_char = hex_char(cmd.lo[15:12]);
      6'd20:   out_char = hex_char(cmd.lo[11:8]);
      6'd21:   out_char = hex_char(cmd.lo[7:4]);
      6'd22:   out_char = hex_char(cmd.lo[3:0]);
      6'd23:   out_char = CH_0;
      6'd24:   out_char = CH_0;
      6'd25:   out_char = hex_char(cmd.data[7:4]);
      6'd26:   out_char = hex_char(cmd.data[3:0]);
      6'd27:   out_char = hex_char(cmd.close_ck[7:4]);
      6'd28:   out_char = hex_char(cmd.close_ck[3:0]);
      6'd29:   out_char = CH_NL;
      6'd30:   out_char = CH_COLON;
      6'd31:   out_char = CH_0;
      6'd32:   out_char = CH_0;
      6'd33:   out_char = CH_0;
      6'd34:   out_char = CH_0;
      6'd35:   out_char = CH_0;
      6'd36:   out_char = CH_0;
      6'd37:   out_char = CH_0;
      6'd38:   out_char = CH_1;
      6'd39:   out_char = CH_F;
      6'd40:   out_char = CH_F;
      6'd41:   out_char = CH_NL;
      default: out_char = CH_NL;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      started <= 1'b0;
      pos     <= '0;
    end else if (fire) begin
      started <= !last_char;
      pos     <= cur + POS_W'(1);
    end
  end

endmodule

// File: rtl/core/intel_hex_record_encoder_top.sv
// The first character of a byte's text is offered once its command, registered in the queue, is at the head.
// The back end gives one character per cycle while out_stall is low; a byte gives two characters plus
// record overhead (up to 42 for one byte), about 2.75 characters per byte on a long run.
// The front end takes a byte per cycle while the two-entry queue has room.
// Reset (synchronous): encoder state cleared, base_address 0, payload_length 1.
module intel_hex_record_encoder_top
  import ihex_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  data_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  out_char,
  output logic        last_char
);

  localparam logic REG_BASE   = 1'b0;
  localparam logic REG_LENGTH = 1'b1;

  logic [31:0]            base_address;
  logic [LENGTH_BITS-1:0] payload_length;
  logic                   cfg_wr;

  cmd_t front_cmd;
  cmd_t head_cmd;
  logic push;
  logic pop;
  logic full;
  logic empty;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;
  assign prdata = (paddr[2] == REG_LENGTH) ? 32'(payload_length) : base_address;

  always_ff @(posedge clk) begin
    if (rst) begin
      base_address   <= '0;
      payload_length <= LENGTH_BITS'(1);
    end else if (cfg_wr) begin
      case (paddr[2])
        REG_BASE:   base_address   <= pwdata;
        REG_LENGTH: payload_length <= pwdata[LENGTH_BITS-1:0];
        default:    base_address   <= base_address;
      endcase
    end
  end

  ihex_front u_front (
    .clk            (clk),
    .rst            (rst),
    .base_address   (base_address),
    .payload_length (payload_length),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .data_byte      (data_byte),
    .full           (full),
    .push           (push),
    .cmd            (front_cmd)
  );

  ihex_queue u_queue (
    .clk    (clk),
    .rst    (rst),
    .push   (push),
    .wr_cmd (front_cmd),
    .full   (full),
    .pop    (pop),
    .rd_cmd (head_cmd),
    .empty  (empty)
  );

  ihex_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd       (head_cmd),
    .empty     (empty),
    .pop       (pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_char  (out_char),
    .last_char (last_char)
  );

endmodule

// File: sim/tb.sv
module tb;
  import ihex_pkg::*;

  localparam logic [2:0] ADDR_BASE = 3'd0;
  localparam logic [2:0] ADDR_LEN  = 3'd4;

  localparam logic [7:0] REC_DATA = 8'h00;
  localparam logic [7:0] REC_EOF  = 8'h01;
  localparam logic [7:0] REC_EXT  = 8'h04;
  localparam logic [7:0] CH_A     = 8'h41;

  localparam int IDLE_PCT      = 27;
  localparam int SETTLE_CYCLES = 48;
  localparam int RANDOM_BYTES  = 200;

  localparam string RESET_TEXT = ":020000040000FA\n:0100000000FF\n:00000001FF\n";

  typedef enum logic {ROW_WRITE, ROW_BYTE} row_kind_t;

  typedef struct packed {
    row_kind_t   kind;
    logic [2:0]  addr;
    logic [31:0] value;
    logic        typed;
  } stim_row_t;

  typedef struct packed {
    logic [7:0] ch;
    logic       last;
  } hex_char_t;

  localparam int SCRIPT_ROWS = 23;
  localparam stim_row_t SCRIPT [SCRIPT_ROWS] = '{
    '{ROW_BYTE,  3'd0,      32'h0000_0000, 1'b1}, // first byte after reset
    '{ROW_BYTE,  3'd0,      32'h0000_0055, 1'b0}, // run finished, dropped
    '{ROW_WRITE, ADDR_LEN,  32'h0000_0000, 1'b0},
    '{ROW_BYTE,  3'd0,      32'h0000_00AA, 1'b0}, // zero length, dropped
    '{ROW_WRITE, ADDR_BASE, 32'hFFFF_FFFA, 1'b0},
    '{ROW_WRITE, ADDR_LEN,  32'hFFFF_FFFF, 1'b0}, // longest length, upper bits dropped
    // record wraps both the 64K page and the 32-bit space
    '{ROW_BYTE,  3'd0,      32'h0000_00FF, 1'b0},
    '{ROW_BYTE,  3'd0,      32'h0000_0080, 1'b0},
    '{ROW_BYTE,  3'd0,      32'h0000_007F, 1'b0},
    '{ROW_BYTE,  3'd0,      32'h0000_0001, 1'b0},
    '{ROW_BYTE,  3'd0,      32'h0000_00FE, 1'b0},
    '{ROW_BYTE,  3'd0,      32'h0000_0000, 1'b0},
    // length below the offset with the record still open
    '{ROW_WRITE, ADDR_LEN,  32'h0000_0005, 1'b0},
    '{ROW_BYTE,  3'd0,      32'h0000_003C, 1'b0},
    // new length hit inside the record: early close then end of file
    '{ROW_WRITE, ADDR_LEN,  32'h0000_0008, 1'b0},
    '{ROW_BYTE,  3'd0,      32'h0000_00A5, 1'b0},
    '{ROW_WRITE, ADDR_LEN,  32'h0000_000A, 1'b0},
    '{ROW_BYTE,  3'd0,      32'h0000_005A, 1'b0},
    '{ROW_BYTE,  3'd0,      32'h0000_00C3, 1'b0},
    // same upper half as last time, so no extended record
    '{ROW_WRITE, ADDR_BASE, 32'h0000_0000, 1'b0},
    '{ROW_WRITE, ADDR_LEN,  32'h0000_000C, 1'b0},
    '{ROW_BYTE,  3'd0,      32'h0000_000F, 1'b0},
    '{ROW_BYTE,  3'd0,      32'h0000_00F0, 1'b0}
  };

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  data_byte = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [7:0]  out_char;
  logic        last_char;

  logic calm = 1'b0;
  int   mismatch_count = 0;

  // encoder state as seen by the predictor
  logic [31:0]            cfg_base = '0;
  logic [LENGTH_BITS-1:0] cfg_len  = LENGTH_BITS'(1);
  logic [LENGTH_BITS-1:0] enc_off  = '0;
  logic [15:0]            enc_upper = '0;
  logic                   enc_upper_ok = 1'b0;
  logic [7:0]             enc_sum  = '0;
  logic [7:0]             enc_left = '0;

  logic [7:0] text_buf[$];
  hex_char_t  pending_text[$];

  intel_hex_record_encoder_top u_dut (
    .clk       (clk),
    .rst       (rst),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .data_byte (data_byte),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_char  (out_char),
    .last_char (last_char)
  );

  always #10 clk = ~clk;

  task automatic flag_mismatch(input string msg);
    if (mismatch_count < 100) begin
      $display("MISMATCH @%0t: %s", $time, msg);
    end
    mismatch_count++;
  endtask

  function automatic logic [7:0] nibble_char(input logic [3:0] v);
    return (v < 4'd10) ? CH_0 + {4'h0, v} : CH_A + {4'h0, v} - 8'd10;
  endfunction

  function automatic void emit_hex(input logic [7:0] v);
    text_buf.push_back(nibble_char(v[7:4]));
    text_buf.push_back(nibble_char(v[3:0]));
  endfunction

  // Text caused by one byte, left in text_buf; empty when the byte is dropped.
  function automatic void encode_byte(input logic [7:0] b);
    logic [LENGTH_BITS-1:0] rem;
    logic [LENGTH_BITS-1:0] nxt;
    logic [7:0]             rec_len;
    logic [31:0]            addr;
    logic [7:0]             ext_sum;
    text_buf.delete();
    if (enc_off >= cfg_len) return;
    if (enc_left == 8'd0) begin
      rem     = cfg_len - enc_off;
      rec_len = (rem > RECORD_BYTES) ? 8'(RECORD_BYTES) : rem[7:0];
      addr    = cfg_base + 32'(enc_off);
      if (!enc_upper_ok || addr[31:16] != enc_upper) begin
        ext_sum = 8'h02 + REC_EXT + addr[31:24] + addr[23:16];
        text_buf.push_back(CH_COLON);
        emit_hex(8'h02);
        emit_hex(8'h00);
        emit_hex(8'h00);
        emit_hex(REC_EXT);
        emit_hex(addr[31:24]);
        emit_hex(addr[23:16]);
        emit_hex(8'h00 - ext_sum);
        text_buf.push_back(CH_NL);
        enc_upper    = addr[31:16];
        enc_upper_ok = 1'b1;
      end
      text_buf.push_back(CH_COLON);
      emit_hex(rec_len);
      emit_hex(addr[15:8]);
      emit_hex(addr[7:0]);
      emit_hex(REC_DATA);
      enc_sum  = rec_len + addr[15:8] + addr[7:0];
      enc_left = rec_len;
    end
    emit_hex(b);
    enc_sum  = enc_sum + b;
    enc_left = enc_left - 8'd1;
    nxt      = enc_off + LENGTH_BITS'(1);
    enc_off  = nxt;
    if (enc_left == 8'd0 || nxt >= cfg_len) begin
      emit_hex(8'h00 - enc_sum);
      text_buf.push_back(CH_NL);
      enc_left = '0;
      enc_sum  = '0;
    end
    if (nxt >= cfg_len) begin
      text_buf.push_back(CH_COLON);
      emit_hex(8'h00);
      emit_hex(8'h00);
      emit_hex(8'h00);
      emit_hex(REC_EOF);
      emit_hex(8'hFF);
      text_buf.push_back(CH_NL);
      enc_off = cfg_len;
    end
  endfunction

  function automatic void commit_text();
    foreach (text_buf[i]) begin
      pending_text.push_back('{ch: text_buf[i], last: (i == text_buf.size() - 1)});
    end
  endfunction

  // All tasks below start and end just after a falling edge.
  task automatic push_byte(input logic [7:0] b, input logic typed, output bit produced);
    while (!calm && $urandom_range(0, 99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid  <= 1'b1;
    data_byte <= b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    encode_byte(b);
    if (typed) begin
      text_buf.delete();
      for (int i = 0; i < RESET_TEXT.len(); i++) text_buf.push_back(RESET_TEXT[i]);
    end
    produced = (text_buf.size() != 0);
    commit_text();
    @(negedge clk);
  endtask

  task automatic apb_write(input logic [2:0] addr, input logic [31:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= value;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    case (addr)
      ADDR_BASE: cfg_base = value;
      ADDR_LEN:  cfg_len  = value[LENGTH_BITS-1:0];
      default: ;
    endcase
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(negedge clk);
  endtask

  // A dropped byte gives no text, so allow the pipe to empty after the last character.
  task automatic wait_idle();
    in_valid <= 1'b0;
    @(negedge clk);
    while (pending_text.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  always @(negedge clk) begin
    out_stall <= !calm && ($urandom_range(0, 99) < IDLE_PCT);
  end

  always @(posedge clk) begin
    hex_char_t want;
    if (!rst && out_valid && !out_stall) begin
      if (pending_text.size() == 0) begin
        flag_mismatch($sformatf("unexpected char %02h last %b", out_char, last_char));
      end else begin
        want = pending_text.pop_front();
        if (out_char !== want.ch) begin
          flag_mismatch($sformatf("out_char %02h, want %02h", out_char, want.ch));
        end
        if (last_char !== want.last) begin
          flag_mismatch($sformatf("last_char %b, want %b (char %02h)",
                                  last_char, want.last, want.ch));
        end
      end
    end
  end

  initial begin
    #8_000_000;
    $display("status: fail");
    $finish;
  end

  initial begin
    bit          produced;
    int          taken;
    int          phase_no;
    int          pick;
    int          n_bytes;
    logic [31:0] new_base;
    logic [15:0] page;
    logic [23:0] new_len;
    logic [7:0]  junk;

    taken    = 0;
    phase_no = 0;
    repeat (11) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    foreach (SCRIPT[i]) begin
      if (SCRIPT[i].kind == ROW_WRITE) begin
        wait_idle();
        apb_write(SCRIPT[i].addr, SCRIPT[i].value);
      end else begin
        push_byte(SCRIPT[i].value[7:0], SCRIPT[i].typed, produced);
      end
    end

    // Most phases reopen the run by moving the length past the current offset.
    while (taken < RANDOM_BYTES) begin
      wait_idle();
      calm <= (phase_no >= 3 && phase_no < 6);
      pick = $urandom_range(0, 9);
      if (pick < 7) begin
        case (pick)
          0: new_base = '0;
          1: new_base = '1;
          2, 3: begin
            // the next byte's address lies just below a 64K page boundary
            page     = 16'($urandom_range(0, 16'hFFFF));
            new_base = {page, 12'hFFF, 4'($urandom_range(0, 15))} - 32'(enc_off);
          end
          default: new_base = $urandom;
        endcase
        apb_write(ADDR_BASE, new_base);
      end
      pick = $urandom_range(0, 19);
      if (pick == 0) new_len = '0;
      else if (pick == 1) new_len = (enc_off > 3) ? enc_off - 24'($urandom_range(0, 3)) : '0;
      else if (pick == 2) new_len = '1;
      else new_len = enc_off + 24'($urandom_range(1, 40));
      junk = 8'($urandom_range(0, 255));
      apb_write(ADDR_LEN, {junk, new_len});
      n_bytes = $urandom_range(1, 40);
      if ($urandom_range(0, 4) == 0) n_bytes += $urandom_range(1, 4);
      repeat (n_bytes) begin
        push_byte(8'($urandom_range(0, 255)), 1'b0, produced);
        if (produced) taken++;
      end
      phase_no++;
    end

    wait_idle();
    if (mismatch_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
